>>> rtl/core/mpba_pkg.sv
// Shared types and constants of the multi-pool block allocator.
`default_nettype none

package mpba_pkg;

  localparam int SIZE_W = 16;
  localparam int CNT_W = 5;
  localparam int BLK_W = 4;
  localparam int POOL_W = 2;
  localparam int STAT_W = 2;
  localparam int REG_POOLS = 4;
  localparam int CFG_AW = 5;
  localparam int CFG_DW = 32;
  localparam int RST_COUNT = 16;
  localparam int RST_SIZE = 64;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE = 1'b1;

  localparam logic [STAT_W-1:0] ST_OK = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_BAD = 2'd2;
  localparam logic [STAT_W-1:0] ST_DOUBLE = 2'd3;

  typedef struct packed {
    logic             alloc;
    logic             rel;
    logic [BLK_W-1:0] idx;
  } pool_op_t;

  typedef struct packed {
    logic             avail;
    logic [BLK_W-1:0] head_blk;
    logic             marked;
  } pool_stat_t;

endpackage

`default_nettype wire

>>> rtl/core/mpba_if.sv
// Request and response channel interfaces of the multi-pool block allocator.
`default_nettype none

interface mpba_req_if
  import mpba_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              opcode;
  logic [SIZE_W-1:0] request_size;
  logic [POOL_W-1:0] free_pool;
  logic [BLK_W-1:0]  free_index;

  modport source (output valid, output opcode, output request_size, output free_pool,
                  output free_index, input ready);
  modport sink (input valid, input opcode, input request_size, input free_pool,
                input free_index, output ready);
endinterface

interface mpba_rsp_if
  import mpba_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [POOL_W-1:0] block_pool;
  logic [BLK_W-1:0]  block_index;

  modport source (output valid, output status, output block_pool, output block_index,
                  input ready);
  modport sink (input valid, input status, input block_pool, input block_index,
                output ready);
endinterface

`default_nettype wire

>>> rtl/core/mpba_cfg_regs.sv
// Configuration registers of the pools with their APB-style access port.
`default_nettype none

module mpba_cfg_regs
  import mpba_pkg::*;
#(
  parameter int NUM_POOLS = 4,
  parameter int MAX_BLOCKS = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [CFG_DW-1:0] pwdata,
  output logic      [CFG_DW-1:0] prdata,
  output logic                   pready,
  output logic      [SIZE_W-1:0] size_o [NUM_POOLS],
  output logic      [CNT_W-1:0]  count_o [NUM_POOLS],
  output logic      [NUM_POOLS-1:0] init_o
);

  localparam int CNT_SAT = (MAX_BLOCKS > 31) ? 31 : MAX_BLOCKS;
  localparam int RST_CNT = (RST_COUNT > CNT_SAT) ? CNT_SAT : RST_COUNT;
  localparam int IDX_W = CFG_AW - 2;

  logic [IDX_W-1:0]     reg_idx;
  logic                 wr_en;
  logic [CNT_W-1:0]     cnt_wr;
  logic [NUM_POOLS-1:0] init_nxt;
  logic [NUM_POOLS-1:0] init_r;

  assign reg_idx = paddr[CFG_AW-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cnt_wr  = (int'(pwdata[CNT_W-1:0]) > CNT_SAT) ? CNT_W'(CNT_SAT) : pwdata[CNT_W-1:0];

  for (genvar p = 0; p < NUM_POOLS; p++) begin : g_pool
    if (p < REG_POOLS) begin : g_reg
      logic [SIZE_W-1:0] size_r;
      logic [CNT_W-1:0]  count_r;
      logic              sel_size;
      logic              sel_cnt;

      assign sel_size = wr_en && (int'(reg_idx) == p);
      assign sel_cnt  = wr_en && (int'(reg_idx) == p + REG_POOLS);
      assign init_nxt[p] = sel_size || sel_cnt;

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          size_r  <= SIZE_W'(RST_SIZE << (2 * p));
          count_r <= CNT_W'(RST_CNT);
        end else begin
          if (sel_size) begin
            size_r <= pwdata[SIZE_W-1:0];
          end
          if (sel_cnt) begin
            count_r <= cnt_wr;
          end
        end
      end

      assign size_o[p]  = size_r;
      assign count_o[p] = count_r;
    end else begin : g_absent
      assign init_nxt[p] = 1'b0;
      assign size_o[p]   = '0;
      assign count_o[p]  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_r <= '0;
    end else begin
      init_r <= init_nxt;
    end
  end

  assign init_o = init_r;

  always_comb begin
    prdata = '0;
    for (int p = 0; p < NUM_POOLS; p++) begin
      if (p < REG_POOLS) begin
        if (int'(reg_idx) == p) begin
          prdata = CFG_DW'(size_o[p]);
        end
        if (int'(reg_idx) == p + REG_POOLS) begin
          prdata = CFG_DW'(count_o[p]);
        end
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/mpba_pool.sv
// One pool: free ring memory, head and free count, write fill count and allocated marks.
`default_nettype none

module mpba_pool
  import mpba_pkg::*;
#(
  parameter int MAX_BLOCKS = 16,
  parameter int RST_CNT = 16
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             init_i,
  input  wire logic [CNT_W-1:0] count_i,
  input  wire pool_op_t         op_i,
  output pool_stat_t            stat_o
);

  localparam int HW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int SW = ((HW > CNT_W) ? HW : CNT_W) + 1;

  logic [BLK_W-1:0]      ring_mem [MAX_BLOCKS];
  logic [BLK_W-1:0]      rd_data_r;
  logic                  virgin_r;
  logic                  virgin_nxt;
  logic [HW-1:0]         head_r;
  logic [HW-1:0]         head_nxt;
  logic [CNT_W-1:0]      fc_r;
  logic [CNT_W-1:0]      fc_nxt;
  logic [CNT_W-1:0]      fill_r;
  logic [CNT_W-1:0]      fill_nxt;
  logic [MAX_BLOCKS-1:0] marks_r;
  logic [MAX_BLOCKS-1:0] marks_nxt;
  logic [SW-1:0]         head_inc;
  logic [SW-1:0]         tail_sum;
  logic [SW-1:0]         tail_pos;
  logic [HW-1:0]         wr_addr;
  logic                  wr_en;
  logic [BLK_W-1:0]      head_blk;
  logic                  marked;

  assign head_blk = virgin_r ? BLK_W'(head_r) : rd_data_r;
  assign head_inc = SW'(head_r) + SW'(1);
  assign tail_sum = SW'(head_r) + SW'(fc_r);
  assign tail_pos = (tail_sum >= SW'(count_i)) ? (tail_sum - SW'(count_i)) : tail_sum;
  assign wr_addr  = tail_pos[HW-1:0];
  assign wr_en    = op_i.rel && !init_i;

  always_comb begin
    head_nxt  = head_r;
    fc_nxt    = fc_r;
    fill_nxt  = fill_r;
    marks_nxt = marks_r;
    if (init_i) begin
      head_nxt  = '0;
      fc_nxt    = count_i;
      fill_nxt  = '0;
      marks_nxt = '0;
    end else if (op_i.alloc) begin
      head_nxt = (head_inc == SW'(count_i)) ? '0 : head_inc[HW-1:0];
      fc_nxt   = fc_r - CNT_W'(1);
      for (int i = 0; i < MAX_BLOCKS; i++) begin
        if (i == int'(head_blk)) begin
          marks_nxt[i] = 1'b1;
        end
      end
    end else if (op_i.rel) begin
      fc_nxt = fc_r + CNT_W'(1);
      if (fill_r < count_i) begin
        fill_nxt = fill_r + CNT_W'(1);
      end
      for (int i = 0; i < MAX_BLOCKS; i++) begin
        if (i == int'(op_i.idx)) begin
          marks_nxt[i] = 1'b0;
        end
      end
    end
  end

  assign virgin_nxt = SW'(head_nxt) >= SW'(fill_nxt);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ring_mem[wr_addr] <= op_i.idx;
    end
    if (wr_en && (wr_addr == head_nxt)) begin
      rd_data_r <= op_i.idx;
    end else begin
      rd_data_r <= ring_mem[head_nxt];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r   <= '0;
      fc_r     <= CNT_W'(RST_CNT);
      fill_r   <= '0;
      marks_r  <= '0;
      virgin_r <= 1'b1;
    end else begin
      head_r   <= head_nxt;
      fc_r     <= fc_nxt;
      fill_r   <= fill_nxt;
      marks_r  <= marks_nxt;
      virgin_r <= virgin_nxt;
    end
  end

  always_comb begin
    marked = 1'b0;
    for (int i = 0; i < MAX_BLOCKS; i++) begin
      if (i == int'(op_i.idx)) begin
        marked = marks_r[i];
      end
    end
  end

  assign stat_o.avail    = (fc_r != '0);
  assign stat_o.head_blk = head_blk;
  assign stat_o.marked   = marked;

  a_fc_bound: assert property (@(posedge clk) disable iff (!rst_n)
    !init_i |-> fc_r <= count_i)
    else $error("free count exceeds block count");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    !init_i |-> fill_r <= count_i)
    else $error("fill count exceeds block count");

  a_alloc_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    op_i.alloc |-> fc_r != '0)
    else $error("allocation from an empty ring");

endmodule

`default_nettype wire

>>> rtl/core/multi_pool_block_allocator_unit.sv
// A request waits in the request register until the response register can take it; its
// response is then registered. One request per cycle is taken while responses are not stalled;
// the pool pick, ring head and tail update all settle between the two registers.
// Reset is synchronous and active low; every pool comes out of reset with a full free ring.
// A configuration write re-initialises its pool on the following cycle.
// Top level of the multi-pool block allocator.
`default_nettype none

module multi_pool_block_allocator_unit
  import mpba_pkg::*;
#(
  parameter int NUM_POOLS = 4,
  parameter int MAX_BLOCKS = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  mpba_req_if.sink               in_req,
  mpba_rsp_if.source             out_rsp,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [CFG_DW-1:0] pwdata,
  output logic      [CFG_DW-1:0] prdata,
  output logic                   pready
);

  localparam int CNT_SAT = (MAX_BLOCKS > 31) ? 31 : MAX_BLOCKS;
  localparam int RST_CNT = (RST_COUNT > CNT_SAT) ? CNT_SAT : RST_COUNT;

  logic [SIZE_W-1:0]    pool_size [NUM_POOLS];
  logic [CNT_W-1:0]     pool_count [NUM_POOLS];
  logic [NUM_POOLS-1:0] pool_init;
  pool_op_t             pool_op [NUM_POOLS];
  pool_stat_t           pool_stat [NUM_POOLS];

  logic              s1_valid_r;
  logic              s1_opcode_r;
  logic [SIZE_W-1:0] s1_size_r;
  logic [POOL_W-1:0] s1_pool_r;
  logic [BLK_W-1:0]  s1_idx_r;
  logic              in_acc;
  logic              advance;
  logic              fire;

  logic              out_valid_r;
  logic [STAT_W-1:0] out_status_r;
  logic [POOL_W-1:0] out_pool_r;
  logic [BLK_W-1:0]  out_idx_r;

  logic              found;
  logic [POOL_W-1:0] pick_pool;
  logic [BLK_W-1:0]  pick_blk;
  logic [NUM_POOLS-1:0] pick_vec;
  logic [NUM_POOLS-1:0] free_vec;
  logic              fp_valid;
  logic [CNT_W-1:0]  fp_count;
  logic              fp_marked;
  logic              bad_handle;
  logic [STAT_W-1:0] status_nxt;
  logic [POOL_W-1:0] rpool_nxt;
  logic [BLK_W-1:0]  ridx_nxt;

  mpba_cfg_regs #(
    .NUM_POOLS  (NUM_POOLS),
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .size_o  (pool_size),
    .count_o (pool_count),
    .init_o  (pool_init)
  );

  for (genvar p = 0; p < NUM_POOLS; p++) begin : g_pool
    assign pool_op[p].alloc = fire && (s1_opcode_r == OP_ALLOC) && pick_vec[p];
    assign pool_op[p].rel   = fire && (s1_opcode_r == OP_FREE) && free_vec[p];
    assign pool_op[p].idx   = s1_idx_r;

    mpba_pool #(
      .MAX_BLOCKS (MAX_BLOCKS),
      .RST_CNT    ((p < REG_POOLS) ? RST_CNT : 0)
    ) u_pool (
      .clk     (clk),
      .rst_n   (rst_n),
      .init_i  (pool_init[p]),
      .count_i (pool_count[p]),
      .op_i    (pool_op[p]),
      .stat_o  (pool_stat[p])
    );
  end

  assign advance = !out_valid_r || out_rsp.ready;
  assign fire    = s1_valid_r && advance;
  assign in_req.ready = !s1_valid_r || advance;
  assign in_acc  = in_req.valid && in_req.ready;

  always_comb begin
    found     = 1'b0;
    pick_pool = '0;
    pick_blk  = '0;
    pick_vec  = '0;
    for (int p = 0; p < NUM_POOLS; p++) begin
      if (!found && pool_stat[p].avail && (s1_size_r <= pool_size[p])) begin
        found       = 1'b1;
        pick_pool   = POOL_W'(p);
        pick_blk    = pool_stat[p].head_blk;
        pick_vec[p] = 1'b1;
      end
    end
  end

  always_comb begin
    fp_valid  = 1'b0;
    fp_count  = '0;
    fp_marked = 1'b0;
    free_vec  = '0;
    for (int p = 0; p < NUM_POOLS; p++) begin
      if (p == int'(s1_pool_r)) begin
        fp_valid  = 1'b1;
        fp_count  = pool_count[p];
        fp_marked = pool_stat[p].marked;
      end
    end
    bad_handle = !fp_valid || (CNT_W'(s1_idx_r) >= fp_count) || (int'(s1_idx_r) >= MAX_BLOCKS);
    for (int p = 0; p < NUM_POOLS; p++) begin
      if (p == int'(s1_pool_r)) begin
        free_vec[p] = !bad_handle && fp_marked;
      end
    end
  end

  always_comb begin
    status_nxt = ST_EMPTY;
    rpool_nxt  = '0;
    ridx_nxt   = '0;
    if (s1_opcode_r == OP_ALLOC) begin
      if (found) begin
        status_nxt = ST_OK;
        rpool_nxt  = pick_pool;
        ridx_nxt   = pick_blk;
      end
    end else if (bad_handle) begin
      status_nxt = ST_BAD;
    end else if (!fp_marked) begin
      status_nxt = ST_DOUBLE;
    end else begin
      status_nxt = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= in_acc || (s1_valid_r && !advance);
      out_valid_r <= fire || (out_valid_r && !out_rsp.ready);
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_opcode_r <= in_req.opcode;
      s1_size_r   <= in_req.request_size;
      s1_pool_r   <= in_req.free_pool;
      s1_idx_r    <= in_req.free_index;
    end
    if (fire) begin
      out_status_r <= status_nxt;
      out_pool_r   <= rpool_nxt;
      out_idx_r    <= ridx_nxt;
    end
  end

  assign out_rsp.valid       = out_valid_r;
  assign out_rsp.status      = out_status_r;
  assign out_rsp.block_pool  = out_pool_r;
  assign out_rsp.block_index = out_idx_r;

  a_unused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_status_r != ST_OK) |-> (out_pool_r == '0) && (out_idx_r == '0))
    else $error("handle fields set on a failed response");

  a_rsp_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_valid_r))
    else $error("response without a request in flight");

  a_single_op: assert property (@(posedge clk) disable iff (!rst_n)
    fire |-> $onehot0(pick_vec) && $onehot0(free_vec))
    else $error("more than one pool updated by one request");

  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && out_valid_r && !out_rsp.ready |-> !in_req.ready)
    else $error("request taken while both stages are full");

endmodule

`default_nettype wire

>>> dv/testbench.sv
// Self-checking testbench of the multi-pool block allocator: random and directed requests.
`timescale 1ns / 100ps

module testbench;
  import mpba_pkg::*;

  localparam int POOLS = REG_POOLS;
  localparam int BLOCKS = 16;
  localparam int REG_SIZE_BASE = 0;
  localparam int REG_COUNT_BASE = REG_POOLS;
  localparam int NUM_REGS = 2 * REG_POOLS;
  localparam int LATENCY = 2;
  localparam int IDLE_LIMIT = 2000;

  typedef struct packed {
    logic              opcode;
    logic [SIZE_W-1:0] request_size;
    logic [POOL_W-1:0] free_pool;
    logic [BLK_W-1:0]  free_index;
  } req_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [POOL_W-1:0] block_pool;
    logic [BLK_W-1:0]  block_index;
  } rsp_t;

  typedef struct {
    logic [SIZE_W-1:0] size  [POOLS];
    logic [CNT_W-1:0]  count [POOLS];
    logic [BLK_W-1:0]  ring  [POOLS][BLOCKS];
    logic [BLK_W-1:0]  head  [POOLS];
    logic [CNT_W-1:0]  nfree [POOLS];
    logic              held  [POOLS][BLOCKS];
  } pool_state_t;

  logic              clk;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  mpba_req_if req_ch ();
  mpba_rsp_if rsp_ch ();

  multi_pool_block_allocator_unit #(
    .NUM_POOLS (POOLS),
    .MAX_BLOCKS(BLOCKS)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_req (req_ch),
    .out_rsp(rsp_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  pool_state_t live_pools;
  pool_state_t gen_pools;
  req_t        pending_requests[$];
  rsp_t        awaited_responses[$];
  req_t        next_req;
  req_t        taken_req;
  rsp_t        want;
  rsp_t        got;
  logic        req_taken;
  int          burst_left;
  int          gap_left;
  logic [15:0] stall_pat;
  logic [5:0]  stall_phase;
  int          idle_cycles;
  int          mismatches;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic void pool_reinit(inout pool_state_t s, input int p);
    for (int b = 0; b < BLOCKS; b++) begin
      s.ring[p][b] = BLK_W'(b);
      s.held[p][b] = 1'b0;
    end
    s.head[p] = '0;
    s.nfree[p] = s.count[p];
  endfunction

  function automatic pool_state_t reset_pools();
    pool_state_t s;
    for (int p = 0; p < POOLS; p++) begin
      s.size[p] = SIZE_W'(RST_SIZE << (2 * p));
      s.count[p] = CNT_W'(RST_COUNT);
      pool_reinit(s, p);
    end
    return s;
  endfunction

  function automatic void reg_write(inout pool_state_t s, input int r, input logic [31:0] v);
    int p;
    p = r % REG_POOLS;
    if (r < REG_COUNT_BASE) begin
      s.size[p] = v[SIZE_W-1:0];
    end else begin
      s.count[p] = (v[CNT_W-1:0] > CNT_W'(BLOCKS)) ? CNT_W'(BLOCKS) : v[CNT_W-1:0];
    end
    pool_reinit(s, p);
  endfunction

  function automatic rsp_t allocator_step(inout pool_state_t s, input req_t r);
    rsp_t             o;
    logic [BLK_W-1:0] b;
    int               p;
    bit               done;
    o.status = ST_EMPTY;
    o.block_pool = '0;
    o.block_index = '0;
    done = 1'b0;
    if (r.opcode == OP_ALLOC) begin
      for (p = 0; p < POOLS; p++) begin
        if (!done && r.request_size <= s.size[p] && s.nfree[p] != 0 && s.count[p] != 0) begin
          b = s.ring[p][s.head[p]];
          s.held[p][b] = 1'b1;
          s.head[p] = BLK_W'((int'(s.head[p]) + 1) % int'(s.count[p]));
          s.nfree[p] = s.nfree[p] - 1'b1;
          o.status = ST_OK;
          o.block_pool = POOL_W'(p);
          o.block_index = b;
          done = 1'b1;
        end
      end
    end else begin
      p = int'(r.free_pool);
      b = r.free_index;
      if (CNT_W'(b) >= s.count[p]) begin
        o.status = ST_BAD;
      end else if (!s.held[p][b]) begin
        o.status = ST_DOUBLE;
      end else begin
        s.ring[p][(int'(s.head[p]) + int'(s.nfree[p])) % int'(s.count[p])] = b;
        s.nfree[p] = s.nfree[p] + 1'b1;
        s.held[p][b] = 1'b0;
        o.status = ST_OK;
      end
    end
    return o;
  endfunction

  function automatic req_t alloc_req(input int size);
    req_t r;
    r.opcode = OP_ALLOC;
    r.request_size = SIZE_W'(size);
    r.free_pool = POOL_W'($urandom);
    r.free_index = BLK_W'($urandom);
    return r;
  endfunction

  function automatic req_t free_req(input int pool, input int idx);
    req_t r;
    r.opcode = OP_FREE;
    r.request_size = SIZE_W'($urandom);
    r.free_pool = POOL_W'(pool);
    r.free_index = BLK_W'(idx);
    return r;
  endfunction

  function automatic req_t make_random_req(input int alloc_pct);
    req_t r;
    int   held_p[$];
    int   held_b[$];
    int   pick;
    r.request_size = SIZE_W'($urandom);
    r.free_pool = POOL_W'($urandom);
    r.free_index = BLK_W'($urandom);
    if ($urandom_range(0, 99) < alloc_pct) begin
      r.opcode = OP_ALLOC;
      pick = $urandom_range(0, 9);
      if (pick < 4) begin
        r.request_size = SIZE_W'(int'(gen_pools.size[$urandom_range(0, POOLS - 1)]) +
                                 $urandom_range(0, 2) - 1);
      end else if (pick < 5) begin
        r.request_size = '0;
      end else if (pick < 6) begin
        r.request_size = '1;
      end else if (pick < 9) begin
        r.request_size = SIZE_W'($urandom_range(0, 4200));
      end
    end else begin
      r.opcode = OP_FREE;
      for (int p = 0; p < POOLS; p++) begin
        for (int b = 0; b < BLOCKS; b++) begin
          if (gen_pools.held[p][b]) begin
            held_p.push_back(p);
            held_b.push_back(b);
          end
        end
      end
      if (held_p.size() > 0 && $urandom_range(0, 3) != 0) begin
        pick = $urandom_range(0, held_p.size() - 1);
        r.free_pool = POOL_W'(held_p[pick]);
        r.free_index = BLK_W'(held_b[pick]);
      end
    end
    return r;
  endfunction

  task automatic queue_req(input req_t r);
    void'(allocator_step(gen_pools, r));
    pending_requests.push_back(r);
  endtask

  task automatic queue_random(input int n);
    int alloc_pct;
    alloc_pct = $urandom_range(40, 75);
    repeat (n) queue_req(make_random_req(alloc_pct));
  endtask

  task automatic write_reg(input int r, input logic [31:0] v);
    logic [31:0] data;
    data = $urandom;
    if (r < REG_COUNT_BASE) data[SIZE_W-1:0] = v[SIZE_W-1:0];
    else data[CNT_W-1:0] = v[CNT_W-1:0];
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= CFG_AW'(4 * r);
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    reg_write(live_pools, r, data);
    reg_write(gen_pools, r, data);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic random_config();
    int forced;
    forced = $urandom_range(0, NUM_REGS - 1);
    for (int r = 0; r < NUM_REGS; r++) begin
      if (r == forced || $urandom_range(0, 1) == 1) begin
        if (r < REG_COUNT_BASE) begin
          case ($urandom_range(0, 3))
            0: write_reg(r, 32'd0);
            1: write_reg(r, 32'hFFFF);
            2: write_reg(r, $urandom_range(0, 5000));
            default: write_reg(r, $urandom);
          endcase
        end else begin
          write_reg(r, ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(1, BLOCKS));
        end
      end
    end
    repeat (3) @(posedge clk);
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (pending_requests.size() != 0 || req_ch.valid || awaited_responses.size() != 0);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  task automatic note_mismatch(input string field, input int exp_v, input int got_v);
    mismatches++;
    $display("%0t: %s expected %0d, got %0d", $time, field, exp_v, got_v);
  endtask

  // Request driver: bursts of transactions separated by random gaps.
  always @(negedge clk) begin
    if (!rst_n) begin
      req_ch.valid <= 1'b0;
    end else if (!req_ch.valid || req_taken) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        req_ch.valid <= 1'b0;
      end else if (pending_requests.size() > 0) begin
        next_req = pending_requests.pop_front();
        req_ch.opcode <= next_req.opcode;
        req_ch.request_size <= next_req.request_size;
        req_ch.free_pool <= next_req.free_pool;
        req_ch.free_index <= next_req.free_index;
        req_ch.valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 24);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // Response back-pressure follows a 16-bit stall pattern that is redrawn whenever the phase counter wraps.
  always @(negedge clk) begin
    if (stall_phase == 6'd0) begin
      stall_pat <= ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom);
    end
    stall_phase <= stall_phase + 1'b1;
    rsp_ch.ready <= rst_n && !stall_pat[stall_phase[3:0]];
  end

  // Monitor: predicts each accepted request and checks each accepted response.
  always @(posedge clk) begin
    req_taken <= rst_n && req_ch.valid && req_ch.ready;
    if (rst_n && req_ch.valid && req_ch.ready) begin
      taken_req.opcode = req_ch.opcode;
      taken_req.request_size = req_ch.request_size;
      taken_req.free_pool = req_ch.free_pool;
      taken_req.free_index = req_ch.free_index;
      awaited_responses.push_back(allocator_step(live_pools, taken_req));
    end
    if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
      got.status = rsp_ch.status;
      got.block_pool = rsp_ch.block_pool;
      got.block_index = rsp_ch.block_index;
      if (awaited_responses.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected response, status %0d pool %0d index %0d", $time,
                 got.status, got.block_pool, got.block_index);
      end else begin
        want = awaited_responses.pop_front();
        if (got.status !== want.status) note_mismatch("status", want.status, got.status);
        if (got.block_pool !== want.block_pool) begin
          note_mismatch("block_pool", want.block_pool, got.block_pool);
        end
        if (got.block_index !== want.block_index) begin
          note_mismatch("block_index", want.block_index, got.block_index);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || psel || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    req_ch.valid = 1'b0;
    req_ch.opcode = OP_ALLOC;
    req_ch.request_size = '0;
    req_ch.free_pool = '0;
    req_ch.free_index = '0;
    rsp_ch.ready = 1'b0;
    req_taken = 1'b0;
    burst_left = 0;
    gap_left = 0;
    stall_pat = '0;
    stall_phase = '0;
    idle_cycles = 0;
    mismatches = 0;
    live_pools = reset_pools();
    gen_pools = reset_pools();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    repeat (3) @(posedge clk);

    // Size boundaries of every pool, no fit, double free and a free of a held block.
    queue_req(alloc_req(0));
    queue_req(alloc_req(64));
    queue_req(alloc_req(65));
    queue_req(alloc_req(256));
    queue_req(alloc_req(257));
    queue_req(alloc_req(1024));
    queue_req(alloc_req(1025));
    queue_req(alloc_req(4096));
    queue_req(alloc_req(4097));
    queue_req(alloc_req(65535));
    queue_req(free_req(0, 0));
    queue_req(free_req(0, 0));
    queue_req(free_req(3, 15));
    queue_req(free_req(1, 0));
    queue_req(alloc_req(200));
    queue_req(free_req(2, 1));
    queue_req(free_req(2, 0));
    queue_random(250);
    wait_drained();

    // Extreme settings: a zero size, a one-block pool, a disabled pool and a saturated count.
    write_reg(REG_SIZE_BASE + 0, 32'd0);
    write_reg(REG_SIZE_BASE + 1, 32'hFFFF);
    write_reg(REG_SIZE_BASE + 2, 32'd1);
    write_reg(REG_SIZE_BASE + 3, 32'hFFFF);
    write_reg(REG_COUNT_BASE + 0, 32'd1);
    write_reg(REG_COUNT_BASE + 1, 32'd0);
    write_reg(REG_COUNT_BASE + 2, 32'd31);
    write_reg(REG_COUNT_BASE + 3, 32'd16);
    repeat (3) @(posedge clk);
    queue_req(alloc_req(0));
    queue_req(alloc_req(0));
    queue_req(free_req(0, 1));
    queue_req(free_req(1, 0));
    queue_req(alloc_req(2));
    queue_req(free_req(0, 0));
    queue_req(alloc_req(65535));
    queue_req(free_req(2, 15));
    queue_random(200);
    wait_drained();

    repeat (3) begin
      random_config();
      queue_random(200);
      wait_drained();
    end

    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/mpba_pkg.sv
rtl/core/mpba_if.sv
rtl/core/mpba_cfg_regs.sv
rtl/core/mpba_pool.sv
rtl/core/multi_pool_block_allocator_unit.sv
dv/testbench.sv
